FILE: rtl/tpc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Thermal protection controller package
// Shared types, register indexes and reset limits.
// ============================================================================
package tpc_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int TEMP_W        = 8;
    localparam int STAMP_W       = 32;
    localparam int LIM_W         = 40;
    localparam int GRACE_W       = 16;
    localparam int IDX_W         = 2;
    localparam int S_DATA_W      = 40;
    localparam int M_DATA_W      = 8;

    // Limit register layout, most significant member first.
    typedef struct packed {
        logic [GRACE_W-1:0] grace;
        logic [TEMP_W-1:0]  safe;
        logic [TEMP_W-1:0]  concern;
        logic [TEMP_W-1:0]  crit;
    } lim_t;

    typedef enum logic [IDX_W-1:0] {
        REG_REBOOT    = 2'd0,
        REG_DEEPSLEEP = 2'd1,
        REG_DECLOCK   = 2'd2,
        REG_UNUSED    = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_SCALED  = 2'd1,
        MODE_MINIMAL = 2'd2,
        MODE_SPARE   = 2'd3
    } clk_mode_t;

    // Result of one zone check for one sample.
    typedef struct packed {
        logic req;
        logic zone;
    } zone_stat_t;

    localparam lim_t REBOOT_LIM_RST = '{grace: 16'd600, safe: 8'd110,
                                        concern: 8'd112, crit: 8'd120};
    localparam lim_t DEEPSLEEP_LIM_RST = '{grace: 16'd600, safe: 8'd100,
                                           concern: 8'd110, crit: 8'd115};
    localparam lim_t DECLOCK_LIM_RST = '{grace: 16'd60, safe: 8'd90,
                                         concern: 8'd100, crit: 8'd110};

endpackage

FILE: rtl/tpc_zone_check.sv
`timescale 1ns / 1ps
// ============================================================================
// Zone check with hysteresis
// Tracks one concern zone and its entry time, and raises a request on a
// critical sample or after the grace time spent in the zone.
// ============================================================================
module tpc_zone_check
    import tpc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  lim_t                 lim,
    input  logic [TEMP_W-1:0]    temp,
    input  logic [TIME_BITS-1:0] now,
    output zone_stat_t           stat
);

    logic                 zone_reg, zone_next;
    logic [TIME_BITS-1:0] start_reg, start_next;
    logic [TIME_BITS-1:0] elapsed;
    logic                 req;

    always_comb begin
        zone_next  = zone_reg;
        start_next = start_reg;
        req        = 1'b0;
        if (lim.grace != '0) begin
            if (temp >= lim.crit) begin
                req = 1'b1;
            end else if (!zone_reg && temp >= lim.concern) begin
                zone_next  = 1'b1;
                start_next = now;
            end else if (zone_reg && temp < lim.safe) begin
                zone_next = 1'b0;
            end
        end
    end

    // Elapsed time wraps with the timestamp width.
    assign elapsed = now - start_next;

    assign stat.req  = req | ((lim.grace != '0) && zone_next &&
                              (elapsed >= TIME_BITS'(lim.grace)));
    assign stat.zone = zone_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_reg  <= 1'b0;
            start_reg <= '0;
        end else if (step) begin
            zone_reg  <= zone_next;
            start_reg <= start_next;
        end
    end

endmodule

FILE: rtl/tpc_declock.sv
`timescale 1ns / 1ps
// ============================================================================
// Declock check
// Steps the clock mode between normal, scaled and minimal, and steps back
// toward normal only after the grace time.
// ============================================================================
module tpc_declock
    import tpc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  lim_t                 lim,
    input  logic [TEMP_W-1:0]    temp,
    input  logic [TIME_BITS-1:0] now,
    output clk_mode_t            mode,
    output logic                 changed
);

    clk_mode_t            mode_reg, mode_next;
    logic [TIME_BITS-1:0] start_reg, start_next;
    logic                 grace_done;

    assign grace_done = (now - start_reg) >= TIME_BITS'(lim.grace);

    always_comb begin
        mode_next  = mode_reg;
        start_next = start_reg;
        if (lim.grace != '0) begin
            if (temp >= lim.crit) begin
                mode_next  = MODE_MINIMAL;
                start_next = now;
            end else if (temp >= lim.concern) begin
                if (mode_reg == MODE_NORMAL) begin
                    mode_next = MODE_SCALED;
                end
                start_next = now;
            end else if (temp > lim.safe) begin
                if (mode_reg == MODE_MINIMAL) begin
                    if (grace_done) begin
                        mode_next  = MODE_SCALED;
                        start_next = now;
                    end
                end else begin
                    start_next = now;
                end
            end else if (mode_reg != MODE_NORMAL && grace_done) begin
                mode_next = MODE_NORMAL;
            end
        end
    end

    assign mode    = mode_next;
    assign changed = (mode_next != mode_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_NORMAL;
            start_reg <= '0;
        end else if (step) begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
        end
    end

endmodule

FILE: rtl/thermal_protection_controller.sv
`timescale 1ns / 1ps
// ============================================================================
// Thermal protection controller
// Deep-sleep, reboot and declock checks with hysteresis on a sample stream.
// ============================================================================
//  Channel   Direction  Handshake              Payload
//  s_        in         s_tvalid / s_tready    temperature, now_seconds
//  m_        out        m_tvalid / m_tready    requests, zone bits, clock mode
//  cfg_      in         cfg_valid / cfg_ready  register index, 40-bit limits
//
//  One sample per cycle is accepted while the output is not stalled; each sample
//  passes through the input register and its result through the result register.
//  Reset restores the limit registers to their defaults and clears the zones,
//  start times and clock mode. A stalled result holds the pipeline, and the
//  input side stays ready while the result register can still move.
// ============================================================================
module thermal_protection_controller
    import tpc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // temperature[7:0], now_seconds[39:8]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // deepsleep_request[0], reboot_request[1],
                                           // deepsleep_zone_active[2],
                                           // reboot_zone_active[3], clock_mode[5:4],
                                           // clock_mode_changed[6], zero[7]
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [LIM_W-1:0]    cfg_data
);

    lim_t reboot_lim_reg, deepsleep_lim_reg, declock_lim_reg;

    logic                in_valid_reg;
    logic [TEMP_W-1:0]   in_temp_reg;
    logic [STAMP_W-1:0]  in_now_reg;
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;

    logic                 advance;
    logic [TIME_BITS-1:0] now_ext;
    zone_stat_t           ds_stat, rb_stat;
    clk_mode_t            mode;
    logic                 mode_changed;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reboot_lim_reg    <= REBOOT_LIM_RST;
            deepsleep_lim_reg <= DEEPSLEEP_LIM_RST;
            declock_lim_reg   <= DECLOCK_LIM_RST;
        end else if (cfg_valid) begin
            unique case (reg_idx_t'(cfg_index))
                REG_REBOOT:    reboot_lim_reg    <= cfg_data;
                REG_DEEPSLEEP: deepsleep_lim_reg <= cfg_data;
                REG_DECLOCK:   declock_lim_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // The sample in the input register is processed when the result register
    // is free or is being emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_temp_reg <= s_tdata[TEMP_W-1:0];
            in_now_reg  <= s_tdata[TEMP_W +: STAMP_W];
        end
    end

    assign now_ext = TIME_BITS'(in_now_reg);

    tpc_zone_check #(
        .TIME_BITS (TIME_BITS)
    ) u_deepsleep (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .lim     (deepsleep_lim_reg),
        .temp    (in_temp_reg),
        .now     (now_ext),
        .stat    (ds_stat)
    );

    tpc_zone_check #(
        .TIME_BITS (TIME_BITS)
    ) u_reboot (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .lim     (reboot_lim_reg),
        .temp    (in_temp_reg),
        .now     (now_ext),
        .stat    (rb_stat)
    );

    tpc_declock #(
        .TIME_BITS (TIME_BITS)
    ) u_declock (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .lim     (declock_lim_reg),
        .temp    (in_temp_reg),
        .now     (now_ext),
        .mode    (mode),
        .changed (mode_changed)
    );

    assign out_data_next = {1'b0, mode_changed, mode, rb_stat.zone, ds_stat.zone,
                            rb_stat.req, ds_stat.req};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
